>>> design/ssfs_pkg.sv
// Shared types, constants and segment tables for the frame sequencer.
package ssfs_pkg;

  typedef enum logic [1:0] {
    CmdBright = 2'd0,
    CmdNumber = 2'd1,
    CmdPair   = 2'd2,
    CmdLetter = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SymStart = 2'd0,
    SymData  = 2'd1,
    SymStop  = 2'd2
  } sym_e;

  localparam logic [7:0] BrightBase = 8'h88;
  localparam logic [7:0] DataMode   = 8'h40;
  localparam logic [5:0] AddrHigh   = 6'b110000;  // upper bits of 0xC0..0xC3
  localparam logic [6:0] PairMax    = 7'd99;

  // floor(n / 10) = (n * 52429) >> 19, exact for n below 43699
  localparam logic [15:0] DivTenMul = 16'd52429;
  // floor(v / 10) = (v * 205) >> 11, exact for v up to 99
  localparam logic [7:0]  DivTenSmall = 8'd205;

  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] BrightLastStep  = 5'd2;
  localparam logic [StepW-1:0] FrameFirstStep  = 5'd3;
  localparam logic [StepW-1:0] LetterFirstStep = 5'd15;
  localparam logic [StepW-1:0] LastStep        = 5'd18;

  function automatic logic [7:0] digit_pat(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] glyph_pat(input logic [4:0] g);
    logic [7:0] p;
    case (g)
      5'd0:    p = 8'h40;
      5'd1:    p = 8'h77;
      5'd2:    p = 8'h7C;
      5'd3:    p = 8'h39;
      5'd4:    p = 8'h5E;
      5'd5:    p = 8'h79;
      5'd6:    p = 8'h71;
      5'd7:    p = 8'h3D;
      5'd8:    p = 8'h74;
      5'd9:    p = 8'h06;
      5'd10:   p = 8'h0E;
      5'd11:   p = 8'h38;
      5'd12:   p = 8'h37;
      5'd13:   p = 8'h3F;
      5'd14:   p = 8'h73;
      5'd15:   p = 8'h31;
      5'd16:   p = 8'h6D;
      5'd17:   p = 8'h78;
      5'd18:   p = 8'h3E;
      default: p = 8'h00;  // blank, also for out-of-range codes
    endcase
    return p;
  endfunction

endpackage

>>> design/seven_segment_frame_sequencer_core.sv
// Top level: expands one display command into start/data/stop bus beats.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | command, level, number,
//           |           |                          | left/right_value, glyph, position
//   out     | output    | out_valid_o / out_ready_i| symbol, payload, last
//
// One output beat per cycle while the out channel is not stalled, from the single
// output register: brightness is 3 beats, letter 4, number and pair 19. The next
// command is accepted in the cycle the previous command's last beat is loaded into
// the output register. Number digits are peeled off one per frame by a
// multiply-by-reciprocal. Reset clears the busy flag and output valid; a stalled
// out channel holds the output register, and the step counter while busy.
module seven_segment_frame_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  level_i,
  input  logic [13:0] number_i,
  input  logic signed [7:0] left_value_i,
  input  logic signed [7:0] right_value_i,
  input  logic [4:0]  glyph_i,
  input  logic [1:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  symbol_o,
  output logic [7:0]  payload_o,
  output logic        last_o
);
  import ssfs_pkg::*;

  logic             busy_q;
  logic [StepW-1:0] step_q;
  cmd_e             cmd_q;
  logic [7:0]       byte_q;   // brightness byte or letter pattern
  logic [1:0]       pos_q;
  logic [13:0]      num_q;
  logic [15:0]      digs_q;   // pair digits, next one in the low nibble

  logic             out_valid_q;
  logic [1:0]       symbol_q;
  logic [7:0]       payload_q;
  logic             last_q;

  logic             advance, emit, accept, seq_last;
  cmd_e             cmd_in;

  // pair clamp and split
  logic [6:0]  left_c, right_c;
  logic [14:0] left_p, right_p;
  logic [3:0]  left_t, right_t, left_u, right_u;

  // number digit
  logic [29:0] num_p;
  logic [10:0] num_div;
  logic [13:0] num_rem;

  // current beat
  logic [3:0]  rel;
  logic [1:0]  frame, phase;
  logic [1:0]  sym_d;
  logic [7:0]  pay_d;
  logic [3:0]  digit;

  function automatic logic [6:0] clamp99(input logic signed [7:0] v);
    logic [6:0] r;
    if (v[7]) begin
      r = 7'd0;
    end else if (v[6:0] > PairMax) begin
      r = PairMax;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  assign cmd_in = cmd_e'(command_i);

  assign left_c  = clamp99(left_value_i);
  assign right_c = clamp99(right_value_i);
  assign left_p  = 15'(left_c) * 15'(DivTenSmall);
  assign right_p = 15'(right_c) * 15'(DivTenSmall);
  assign left_t  = left_p[14:11];
  assign right_t = right_p[14:11];
  assign left_u  = 4'(left_c - 7'(left_t) * 7'd10);
  assign right_u = 4'(right_c - 7'(right_t) * 7'd10);

  assign num_p   = 30'(num_q) * 30'(DivTenMul);
  assign num_div = num_p[29:19];
  assign num_rem = num_q - 14'(num_div) * 14'd10;

  assign advance  = !out_valid_q || out_ready_i;
  assign emit     = busy_q && advance;
  assign seq_last = (cmd_q == CmdBright) ? (step_q == BrightLastStep) : (step_q == LastStep);
  assign in_ready_o = !busy_q || (advance && seq_last);
  assign accept   = in_valid_i && in_ready_o;

  assign rel   = 4'(step_q - FrameFirstStep);
  assign frame = rel[3:2];
  assign phase = rel[1:0];
  assign digit = (cmd_q == CmdPair) ? digs_q[3:0] : num_rem[3:0];

  always_comb begin
    sym_d = SymStart;
    pay_d = 8'h00;
    if (step_q < FrameFirstStep) begin
      case (step_q[1:0])
        2'd0:    sym_d = SymStart;
        2'd1: begin
          sym_d = SymData;
          pay_d = (cmd_q == CmdBright) ? byte_q : DataMode;
        end
        default: sym_d = SymStop;
      endcase
    end else begin
      case (phase)
        2'd0: sym_d = SymStart;
        2'd1: begin
          sym_d = SymData;
          case (cmd_q)
            CmdNumber: pay_d = {AddrHigh, ~frame};  // units digit goes to 0xC3
            CmdPair:   pay_d = {AddrHigh, frame};
            default:   pay_d = {AddrHigh, pos_q};
          endcase
        end
        2'd2: begin
          sym_d = SymData;
          pay_d = (cmd_q == CmdLetter) ? byte_q : digit_pat(digit);
        end
        default: sym_d = SymStop;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= (cmd_in == CmdLetter) ? LetterFirstStep : '0;
    end else if (emit) begin
      if (seq_last) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_in;
      pos_q  <= position_i;
      num_q  <= number_i;
      digs_q <= {right_u, right_t, left_u, left_t};
      byte_q <= (cmd_in == CmdBright) ? (BrightBase | {5'd0, level_i}) : glyph_pat(glyph_i);
    end else if (emit && step_q >= FrameFirstStep && phase == 2'd3) begin
      num_q  <= 14'(num_div);
      digs_q <= {4'd0, digs_q[15:4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      symbol_q  <= sym_d;
      payload_q <= pay_d;
      last_q    <= seq_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign payload_o   = payload_q;
  assign last_o      = last_q;

endmodule

>>> design/ssfs_checker.sv
// Port-level checks for the frame sequencer, bound to the top level.
module ssfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  symbol_o,
  input logic [7:0]  payload_o,
  input logic        last_o
);
  import ssfs_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
      && $stable(payload_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_o != SymData |-> payload_o == 8'h00)
    else $error("start/stop beat carries a nonzero byte");

  a_last_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> symbol_o == SymStop)
    else $error("last beat is not a stop condition");

  // a valid beat that follows an accepted stop, last or not, must open a new frame
  a_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && symbol_o == SymStop ##1 out_valid_o
      |-> symbol_o == SymStart)
    else $error("frame does not open with a start condition");

endmodule

bind seven_segment_frame_sequencer_core ssfs_checker u_ssfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .symbol_o    (symbol_o),
  .payload_o   (payload_o),
  .last_o      (last_o)
);
